// ===== src/fbp_pkg.sv =====
// shared types, constants and crc step for the framed block parser
`default_nettype none
package fbp_pkg;

  localparam int CNT_W     = 34;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] LEAD_END   = 34'd2;
  localparam logic [CNT_W-1:0] ID_END     = 34'd6;
  localparam logic [CNT_W-1:0] MID_END    = 34'd8;
  localparam logic [CNT_W-1:0] NUM_END    = 34'd12;
  localparam logic [CNT_W-1:0] HDR_BYTES  = 34'd16;
  localparam logic [CNT_W-1:0] TRL_BYTES  = 34'd8;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_EXCEEDS     = 3'd2,
    ST_BAD_TRAILER = 3'd3,
    ST_CRC_BAD     = 3'd4
  } fbp_status_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } fbp_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } fbp_in_t;

  typedef struct packed {
    fbp_kind_t   kind;
    logic [7:0]  data_byte;
    fbp_status_t status;
    logic [15:0] lead_rsvd;
    logic [31:0] file_id;
    logic [15:0] mid_rsvd;
    logic [31:0] block_number;
    logic [31:0] data_len;
    logic        has_trailer;
    logic [31:0] trail_rsvd;
    logic [31:0] crc_value;
  } fbp_res_t;

  // results produced by one accepted item, in delivery order
  typedef struct packed {
    logic [1:0] n;
    fbp_res_t   e0;
    fbp_res_t   e1;
  } fbp_push_t;

  // msb-first crc-32 over one byte
  function automatic logic [31:0] crc_byte(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/file_block_frame_parser_crc_top.sv =====
// top level of the framed block parser with crc-32/bzip2 check
// one payload byte per item, last_byte marking the end of a frame. the first
// sixteen bytes are captured as a big-endian header; the declared number of
// data bytes after it are forwarded one result each and folded into a
// crc-32/bzip2; anything beyond the data is kept as tail bytes. the final byte
// yields a summary result (after its own data result if it is a data byte).
// an item is taken every cycle while in_stall is low: the byte is processed in
// the cycle it is accepted and its results are visible from the next cycle,
// out of a four-entry result queue. in_stall rises only while that queue
// holds more than two results.
`default_nettype none
module file_block_frame_parser_crc_top import fbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fbp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output fbp_res_t      out_data
);

  fbp_push_t push;
  logic      q_full2;
  logic      accept;

  // byte taken when the queue can absorb the worst case of two results
  assign in_stall = q_full2;
  assign accept   = in_valid && !q_full2;

  // frame state, crc and result build
  fbp_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push)
  );

  // result queue between the parser and the output channel
  fbp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (q_full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== src/fbp_parse.sv =====
// header capture, crc fold, tail shift and summary build for one byte
`default_nettype none
module fbp_parse import fbp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire fbp_in_t   item,
  output fbp_push_t      push
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      lead_r, lead_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [15:0]      mid_r, mid_nxt;
  logic [31:0]      num_r, num_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [63:0]      tail_r, tail_nxt;

  always_comb begin
    logic [7:0]       b;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] data_end;
    logic [CNT_W-1:0] end_u;
    logic [CNT_W-1:0] total;
    logic [15:0]      lead_u;
    logic [31:0]      id_u;
    logic [15:0]      mid_u;
    logic [31:0]      num_u;
    logic [31:0]      len_u;
    logic [31:0]      crc_u;
    logic [63:0]      tail_u;
    fbp_res_t         data_res;
    fbp_res_t         sum_res;
    logic             is_data;

    b        = item.in_byte;
    pos      = count_r;
    data_end = HDR_BYTES + {{(CNT_W-32){1'b0}}, len_r};
    lead_u   = lead_r;
    id_u     = id_r;
    mid_u    = mid_r;
    num_u    = num_r;
    len_u    = len_r;
    crc_u    = crc_r;
    tail_u   = tail_r;
    is_data  = 1'b0;

    if (pos < LEAD_END) begin
      lead_u = {lead_r[7:0], b};
    end else if (pos < ID_END) begin
      id_u = {id_r[23:0], b};
    end else if (pos < MID_END) begin
      mid_u = {mid_r[7:0], b};
    end else if (pos < NUM_END) begin
      num_u = {num_r[23:0], b};
    end else if (pos < HDR_BYTES) begin
      len_u = {len_r[23:0], b};
    end else if (pos < data_end) begin
      crc_u   = crc_byte(crc_r, b);
      is_data = 1'b1;
    end else begin
      tail_u = {tail_r[55:0], b};
    end

    total = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;
    end_u = HDR_BYTES + {{(CNT_W-32){1'b0}}, len_u};

    data_res           = '0;
    data_res.kind      = KIND_DATA;
    data_res.data_byte = b;

    sum_res      = '0;
    sum_res.kind = KIND_SUMMARY;
    if (total < HDR_BYTES) begin
      sum_res.status = ST_SHORT;
    end else if (total < end_u) begin
      sum_res.status = ST_EXCEEDS;
    end else begin
      sum_res.lead_rsvd    = lead_u;
      sum_res.file_id      = id_u;
      sum_res.mid_rsvd     = mid_u;
      sum_res.block_number = num_u;
      sum_res.data_len     = len_u;
      if (total == end_u) begin
        sum_res.status = ST_OK;
      end else if (total == end_u + TRL_BYTES) begin
        sum_res.has_trailer = 1'b1;
        sum_res.trail_rsvd  = tail_u[63:32];
        sum_res.crc_value   = tail_u[31:0];
        sum_res.status = ((crc_u ^ CRC_INIT) == tail_u[31:0]) ? ST_OK : ST_CRC_BAD;
      end else begin
        sum_res.status = ST_BAD_TRAILER;
      end
    end

    count_nxt = count_r;
    lead_nxt  = lead_r;
    id_nxt    = id_r;
    mid_nxt   = mid_r;
    num_nxt   = num_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    tail_nxt  = tail_r;
    push      = '0;

    if (accept) begin
      if (item.last_byte) begin
        // frame closes: back to the idle frame state
        count_nxt = '0;
        lead_nxt  = '0;
        id_nxt    = '0;
        mid_nxt   = '0;
        num_nxt   = '0;
        len_nxt   = '0;
        crc_nxt   = CRC_INIT;
        tail_nxt  = '0;
        if (is_data) begin
          push.n  = 2'd2;
          push.e0 = data_res;
          push.e1 = sum_res;
        end else begin
          push.n  = 2'd1;
          push.e0 = sum_res;
        end
      end else begin
        count_nxt = total;
        lead_nxt  = lead_u;
        id_nxt    = id_u;
        mid_nxt   = mid_u;
        num_nxt   = num_u;
        len_nxt   = len_u;
        crc_nxt   = crc_u;
        tail_nxt  = tail_u;
        if (is_data) begin
          push.n  = 2'd1;
          push.e0 = data_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lead_r  <= '0;
      id_r    <= '0;
      mid_r   <= '0;
      num_r   <= '0;
      len_r   <= '0;
      crc_r   <= CRC_INIT;
      tail_r  <= '0;
    end else begin
      count_r <= count_nxt;
      lead_r  <= lead_nxt;
      id_r    <= id_nxt;
      mid_r   <= mid_nxt;
      num_r   <= num_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/fbp_outq.sv =====
// small result queue taking up to two items a cycle, giving one while out_stall is low
`default_nettype none
module fbp_outq import fbp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fbp_push_t push,
  output logic           full2,
  output logic           out_valid,
  input  wire logic      out_stall,
  output fbp_res_t       out_data
);

  fbp_res_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && !out_stall;
  // room for two more items is needed before taking a byte
  assign full2     = (cnt_r > QCNT_W'(QDEPTH - 2));
  assign wr_p1     = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.n);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[wr_p1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire
